// ===== src/pculim_pkg.sv =====
// ----------------------------------------------------------------------------
// pculim_pkg
// Shared types and constants for the per-user connection limiter.
// ----------------------------------------------------------------------------
package pculim_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DEPTH_MAX     = 16384;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;
    localparam int UID_W  = 32;
    localparam int CID_W  = 31;
    localparam int OUT_CNT_W = 7;

    localparam logic [CFG_W-1:0] MAX_TOTAL_RST    = 7'd40;
    localparam logic [CFG_W-1:0] MAX_PER_USER_RST = 7'd40;
    localparam logic             LOOKUP_RST       = 1'b1;

    localparam logic [IDX_W-1:0] CFG_MAX_TOTAL    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_PER_USER = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LOOKUP       = 2'd2;

    typedef enum logic [2:0] {
        ST_ADMIT     = 3'd0,
        ST_DENY_USER = 3'd1,
        ST_DENY_FULL = 3'd2,
        ST_ENDED     = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

// ===== src/pculim_table.sv =====
// ----------------------------------------------------------------------------
// pculim_table
// Key/value table in a synchronous memory with a linear search engine.
// One entry is read per cycle; compare runs in the cycle after the read.
// ----------------------------------------------------------------------------
module pculim_table #(
    parameter  int DEPTH = 64,
    parameter  int KEY_W = 32,
    parameter  int VAL_W = 7,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   scan_start,
    input  logic [KEY_W-1:0]       scan_key,
    input  logic [CW-1:0]          scan_len,
    output pculim_pkg::scan_stat_t scan_stat,
    output logic [AW-1:0]          hit_idx,
    output logic [VAL_W-1:0]       hit_val,
    input  logic [AW-1:0]          rd_addr,
    output logic [KEY_W-1:0]       rd_key,
    output logic [VAL_W-1:0]       rd_val,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [KEY_W-1:0]       wr_key,
    input  logic [VAL_W-1:0]       wr_val
);
    import pculim_pkg::*;

    localparam int EW = KEY_W + VAL_W;

    logic [EW-1:0]    mem [DEPTH];
    logic [EW-1:0]    rdata_reg;
    logic             busy_reg;
    logic             chk_vld_reg;
    logic             done_reg;
    logic             hit_reg;
    logic [CW-1:0]    ptr_reg;
    logic [CW-1:0]    len_reg;
    logic [AW-1:0]    chk_idx_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic [VAL_W-1:0] hit_val_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AW-1:0]    raddr;
    logic             match;
    logic             exhaust;

    assign raddr   = busy_reg ? ptr_reg[AW-1:0] : rd_addr;
    assign match   = chk_vld_reg && (rdata_reg[EW-1:VAL_W] == key_reg);
    assign exhaust = (ptr_reg >= len_reg);

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= busy_reg && !scan_start && (match || exhaust);
            if (scan_start) begin
                busy_reg    <= 1'b1;
                chk_vld_reg <= 1'b0;
            end else if (busy_reg) begin
                if (match || exhaust) begin
                    busy_reg    <= 1'b0;
                    chk_vld_reg <= 1'b0;
                end else begin
                    chk_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_start) begin
            key_reg <= scan_key;
            len_reg <= scan_len;
            ptr_reg <= '0;
        end else if (busy_reg) begin
            if (match || exhaust) begin
                hit_reg     <= match;
                hit_idx_reg <= chk_idx_reg;
                hit_val_reg <= rdata_reg[VAL_W-1:0];
            end else begin
                chk_idx_reg <= ptr_reg[AW-1:0];
                ptr_reg     <= ptr_reg + 1'b1;
            end
        end
    end

    assign scan_stat = '{done: done_reg, hit: hit_reg};
    assign hit_idx   = hit_idx_reg;
    assign hit_val   = hit_val_reg;
    assign rd_key    = rdata_reg[EW-1:VAL_W];
    assign rd_val    = rdata_reg[VAL_W-1:0];

endmodule

// ===== src/per_user_connection_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_user_connection_limiter_unit
// Admission control for connections, limited in total and per user.
//
// Input words (s_*): s_tuser is the command (0 connect, 1 connection ended),
// s_tdata carries the user id and the connection id. Every input word gives
// exactly one result word (m_*): m_tuser is the status, m_tdata the owner,
// its connection count and the live total.
// Connections and users live in two tables in synchronous memories, each
// searched linearly at one entry per cycle. A connect searches the user
// table; an end searches the connection table, then the user table.
// Items are handled one at a time.
// The result sits in an output register: while it waits for m_tready the
// next input word is accepted and worked on; the block stalls only when a
// second result is ready before the first was taken.
// Reset empties both tables at once (live counts cleared, no clearing pass)
// and loads the configuration defaults. Configuration is written through
// cfg_* whenever the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module per_user_connection_limiter_unit #(
    parameter int DEPTH = pculim_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // cfg
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pculim_pkg::IDX_W-1:0] cfg_index,
    input  logic [pculim_pkg::CFG_W-1:0] cfg_data,
    // input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,  // user_id[31:0], conn_id[62:32]
    input  logic [0:0]                   s_tuser,  // cmd[0]
    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,  // owner_id[31:0], owner_conns[38:32],
                                                   // total_conns[45:39]
    output logic [2:0]                   m_tuser   // status[2:0]
);
    import pculim_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [2:0] {
        IDLE, C_SCAN, C_LAST, U_SCAN, EVAL, U_LAST, RESULT
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   max_total_reg;
    logic [CFG_W-1:0]   max_per_user_reg;
    logic               lookup_reg;
    logic [CW-1:0]      conn_live_reg;
    logic [CW-1:0]      user_live_reg;
    logic               cmd_reg;
    logic [UID_W-1:0]   uid_reg;
    logic [CID_W-1:0]   cid_reg;
    logic [UID_W-1:0]   owner_reg;
    logic [AW-1:0]      cidx_reg;
    logic               found_reg;
    logic [AW-1:0]      uidx_reg;
    logic [CW-1:0]      num_reg;
    status_t            res_status_reg;
    logic [UID_W-1:0]   res_owner_reg;
    logic [CW-1:0]      res_oc_reg;
    logic [CW-1:0]      res_tc_reg;
    logic               m_tvalid_reg;
    status_t            m_status_reg;
    logic [UID_W-1:0]   m_owner_reg;
    logic [OUT_CNT_W-1:0] m_oc_reg;
    logic [OUT_CNT_W-1:0] m_tc_reg;

    logic               accept;
    logic               in_cmd;
    logic [UID_W-1:0]   in_uid;
    logic [CID_W-1:0]   in_cid;
    logic [UID_W-1:0]   eff_uid;
    logic [LW-1:0]      mt_raw;
    logic [LW-1:0]      mt_eff;
    logic [LW-1:0]      mpu_raw;
    logic [LW-1:0]      mpu_eff;
    logic               full;
    logic               over;
    logic               admit;
    logic [CW-1:0]      conn_dec;
    logic [CW-1:0]      user_dec;
    logic [CW-1:0]      num_inc;
    logic [CW-1:0]      cnt_dec;
    logic               end_wr;

    // conn table: key = connection id, value = owner
    logic               c_scan_start;
    scan_stat_t         c_stat;
    logic [AW-1:0]      c_hit_idx;
    logic [UID_W-1:0]   c_hit_val;
    logic [CID_W-1:0]   c_rd_key;
    logic [UID_W-1:0]   c_rd_val;
    logic               c_wr_en;
    logic [AW-1:0]      c_wr_addr;
    logic [CID_W-1:0]   c_wr_key;
    logic [UID_W-1:0]   c_wr_val;

    // user table: key = user id, value = connection count
    logic               u_scan_start;
    logic [UID_W-1:0]   u_scan_key;
    scan_stat_t         u_stat;
    logic [AW-1:0]      u_hit_idx;
    logic [CW-1:0]      u_hit_val;
    logic [UID_W-1:0]   u_rd_key;
    logic [CW-1:0]      u_rd_val;
    logic               u_wr_en;
    logic [AW-1:0]      u_wr_addr;
    logic [UID_W-1:0]   u_wr_key;
    logic [CW-1:0]      u_wr_val;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser[0];
    assign in_uid    = s_tdata[31:0];
    assign in_cid    = s_tdata[62:32];
    assign eff_uid   = lookup_reg ? in_uid : '0;

    // effective limits
    always_comb begin
        mt_raw  = LW'(max_total_reg);
        mt_eff  = mt_raw;
        if (mt_raw == '0) begin
            mt_eff = LW'(1);
        end else if (mt_raw > LW'(DEPTH)) begin
            mt_eff = LW'(DEPTH);
        end
        mpu_raw = LW'(max_per_user_reg);
        mpu_eff = (!lookup_reg || (mpu_raw > mt_eff)) ? mt_eff : mpu_raw;
    end

    assign full     = (LW'(conn_live_reg) >= mt_eff);
    assign over     = (LW'(num_reg) >= mpu_eff);
    assign admit    = (state_reg == EVAL) && !cmd_reg && !full && !over;
    assign conn_dec = conn_live_reg - 1'b1;
    assign user_dec = user_live_reg - 1'b1;
    assign num_inc  = num_reg + 1'b1;
    assign cnt_dec  = (num_reg == '0) ? '0 : num_reg - 1'b1;
    assign end_wr   = (state_reg == EVAL) && cmd_reg && found_reg && (cnt_dec != '0);

    assign c_scan_start = accept && in_cmd;
    assign u_scan_start = (accept && !in_cmd) || (state_reg == C_LAST);
    assign u_scan_key   = (state_reg == C_LAST) ? owner_reg : eff_uid;

    // conn table writes: move last entry into the freed slot, or append
    always_comb begin
        c_wr_en   = 1'b0;
        c_wr_addr = conn_live_reg[AW-1:0];
        c_wr_key  = cid_reg;
        c_wr_val  = uid_reg;
        if (state_reg == C_LAST) begin
            c_wr_en   = 1'b1;
            c_wr_addr = cidx_reg;
            c_wr_key  = c_rd_key;
            c_wr_val  = c_rd_val;
        end else if (admit) begin
            c_wr_en   = 1'b1;
        end
    end

    // user table writes
    always_comb begin
        u_wr_en   = 1'b0;
        u_wr_addr = uidx_reg;
        u_wr_key  = uid_reg;
        u_wr_val  = num_inc;
        if (state_reg == U_LAST) begin
            u_wr_en   = 1'b1;
            u_wr_key  = u_rd_key;
            u_wr_val  = u_rd_val;
        end else if (end_wr) begin
            u_wr_en   = 1'b1;
            u_wr_key  = owner_reg;
            u_wr_val  = cnt_dec;
        end else if (admit) begin
            u_wr_en   = 1'b1;
            if (!found_reg) begin
                u_wr_addr = user_live_reg[AW-1:0];
                u_wr_val  = CW'(1);
            end
        end
    end

    pculim_table #(
        .DEPTH (DEPTH),
        .KEY_W (CID_W),
        .VAL_W (UID_W)
    ) u_conn_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_start (c_scan_start),
        .scan_key   (in_cid),
        .scan_len   (conn_live_reg),
        .scan_stat  (c_stat),
        .hit_idx    (c_hit_idx),
        .hit_val    (c_hit_val),
        .rd_addr    (conn_dec[AW-1:0]),
        .rd_key     (c_rd_key),
        .rd_val     (c_rd_val),
        .wr_en      (c_wr_en),
        .wr_addr    (c_wr_addr),
        .wr_key     (c_wr_key),
        .wr_val     (c_wr_val)
    );

    pculim_table #(
        .DEPTH (DEPTH),
        .KEY_W (UID_W),
        .VAL_W (CW)
    ) u_user_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_start (u_scan_start),
        .scan_key   (u_scan_key),
        .scan_len   (user_live_reg),
        .scan_stat  (u_stat),
        .hit_idx    (u_hit_idx),
        .hit_val    (u_hit_val),
        .rd_addr    (user_dec[AW-1:0]),
        .rd_key     (u_rd_key),
        .rd_val     (u_rd_val),
        .wr_en      (u_wr_en),
        .wr_addr    (u_wr_addr),
        .wr_key     (u_wr_key),
        .wr_val     (u_wr_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= IDLE;
            max_total_reg    <= MAX_TOTAL_RST;
            max_per_user_reg <= MAX_PER_USER_RST;
            lookup_reg       <= LOOKUP_RST;
            conn_live_reg    <= '0;
            user_live_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MAX_TOTAL:    max_total_reg    <= cfg_data;
                    CFG_MAX_PER_USER: max_per_user_reg <= cfg_data;
                    CFG_LOOKUP:       lookup_reg       <= cfg_data[0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        cmd_reg   <= in_cmd;
                        cid_reg   <= in_cid;
                        uid_reg   <= eff_uid;
                        state_reg <= in_cmd ? C_SCAN : U_SCAN;
                    end
                end
                C_SCAN: begin
                    if (c_stat.done) begin
                        if (c_stat.hit) begin
                            owner_reg <= c_hit_val;
                            cidx_reg  <= c_hit_idx;
                            state_reg <= C_LAST;
                        end else begin
                            res_status_reg <= ST_UNKNOWN;
                            res_owner_reg  <= '0;
                            res_oc_reg     <= '0;
                            res_tc_reg     <= conn_live_reg;
                            state_reg      <= RESULT;
                        end
                    end
                end
                C_LAST: begin
                    conn_live_reg <= conn_dec;
                    state_reg     <= U_SCAN;
                end
                U_SCAN: begin
                    if (u_stat.done) begin
                        found_reg <= u_stat.hit;
                        uidx_reg  <= u_hit_idx;
                        num_reg   <= u_stat.hit ? u_hit_val : '0;
                        state_reg <= EVAL;
                    end
                end
                EVAL: begin
                    if (!cmd_reg) begin
                        state_reg     <= RESULT;
                        res_owner_reg <= uid_reg;
                        if (full) begin
                            res_status_reg <= ST_DENY_FULL;
                            res_oc_reg     <= num_reg;
                            res_tc_reg     <= conn_live_reg;
                        end else if (over) begin
                            res_status_reg <= ST_DENY_USER;
                            res_oc_reg     <= num_reg;
                            res_tc_reg     <= conn_live_reg;
                        end else begin
                            res_status_reg <= ST_ADMIT;
                            res_oc_reg     <= found_reg ? num_inc : CW'(1);
                            res_tc_reg     <= conn_live_reg + 1'b1;
                            conn_live_reg  <= conn_live_reg + 1'b1;
                            if (!found_reg) begin
                                user_live_reg <= user_live_reg + 1'b1;
                            end
                        end
                    end else begin
                        res_status_reg <= ST_ENDED;
                        res_owner_reg  <= owner_reg;
                        res_tc_reg     <= conn_live_reg;
                        res_oc_reg     <= found_reg ? cnt_dec : '0;
                        if (found_reg && (cnt_dec == '0)) begin
                            // emptied user: pull last entry into its slot
                            user_live_reg <= user_dec;
                            state_reg     <= U_LAST;
                        end else begin
                            state_reg     <= RESULT;
                        end
                    end
                end
                U_LAST: begin
                    state_reg <= RESULT;
                end
                RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_owner_reg  <= res_owner_reg;
                        m_oc_reg     <= OUT_CNT_W'(res_oc_reg);
                        m_tc_reg     <= OUT_CNT_W'(res_tc_reg);
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_tc_reg, m_oc_reg, m_owner_reg};

endmodule
